@@ design/sqff_pkg.sv @@
// Package for the saturating Q15 FIR filter: field and accumulator types,
// clamp limits, rounding preload and coefficient reset value.
// Used by every module of the block; depends on nothing.
package sqff_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int ACC_W       = 31;
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int COEF_COUNT  = 8;
  localparam int CFG_IDX_W   = $clog2(COEF_COUNT);
  localparam int TAPS_DEFAULT = 8;

  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  localparam sample_t COEF_RESET = 16'sd4096;
  localparam acc_t    ROUND_HALF = 31'sd16384;
  localparam acc_t    ACC_MAX    = 31'sh3fffffff;
  localparam acc_t    ACC_MIN    = 31'sh40000000;

endpackage

@@ design/sqff_cell.sv @@
// One tap cell of the saturating Q15 FIR filter: multiply, add and clamp,
// then register the partial sum and the shifted sample window.
// Depends on sqff_pkg.
module sqff_cell #(
  parameter int TAPS = sqff_pkg::TAPS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               valid_in,
  input  sqff_pkg::acc_t                     acc_in,
  input  sqff_pkg::sample_t [TAPS-1:0]       win_in,
  input  sqff_pkg::sample_t                  coef,
  output logic                               valid_out,
  output sqff_pkg::acc_t                     acc_out,
  output sqff_pkg::sample_t [TAPS-1:0]       win_out
);
  import sqff_pkg::*;

  localparam int SUM_W = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(ACC_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(ACC_MIN);

  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   sum;
  acc_t                      acc_next;
  sample_t [TAPS-1:0]        win_next;

  always_comb begin
    prod = $signed(coef) * $signed(win_in[0]);
    sum  = SUM_W'(acc_in) + SUM_W'(prod);
    priority if (sum > SUM_MAX) begin
      acc_next = ACC_MAX;
    end else if (sum < SUM_MIN) begin
      acc_next = ACC_MIN;
    end else begin
      acc_next = ACC_W'(sum);
    end
    for (int i = 0; i < TAPS - 1; i++) begin
      win_next[i] = win_in[i+1];
    end
    win_next[TAPS-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_out <= acc_next;
      win_out <= win_next;
    end
  end

endmodule

@@ design/saturating_q15_fir_filter.sv @@
// Saturating Q15 FIR filter, top level: coefficient registers, sample
// history and a chain of TAPS tap cells. Depends on sqff_pkg, sqff_cell.
// Each input reaches its output through the registers of all TAPS cells.
// Throughput: one sample per cycle unless the output stalls; the chain of
// TAPS multiply-add cells holds up to TAPS in flight and stalls as a whole.
// Reset (synchronous, rst high): coefficients return to 4096, the history
// is cleared to zero and every pipeline stage is emptied.
module saturating_q15_fir_filter #(
  parameter int TAPS = sqff_pkg::TAPS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  sqff_pkg::sample_t  sample_in,
  // Output channel.
  output logic               out_valid,
  input  logic               out_stall,
  output sqff_pkg::sample_t  sample_out,
  // Coefficient write port.
  input  logic               wr_en,
  input  sqff_pkg::cfg_idx_t wr_index,
  input  sqff_pkg::sample_t  wr_data
);
  import sqff_pkg::*;

  // The coefficient bank always holds all eight registers, so writes to
  // coefficients beyond TAPS are kept but never used.
  sample_t [COEF_COUNT-1:0] coefs;

  // Previous TAPS-1 samples, newest at index 0, kept in a shift line.
  sample_t [TAPS-2:0] hist;

  // Sample window entering the first cell: the new sample in lane 0 and
  // older samples after it. Each cell consumes lane 0 and shifts down.
  sample_t [TAPS-1:0] win0;

  // Per-stage signals of the chain; entry k feeds cell k.
  logic               valid_c [TAPS+1];
  acc_t               acc_c   [TAPS+1];
  sample_t [TAPS-1:0] win_c   [TAPS+1];

  logic advance;
  logic in_xfer;

  // The whole chain moves together whenever the last stage is empty or its
  // result is being taken. A stalled output therefore freezes every cell.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign in_xfer  = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= {COEF_COUNT{COEF_RESET}};
    end else if (wr_en) begin
      coefs[wr_index] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (in_xfer) begin
      hist[0] <= sample_in;
      for (int i = 1; i < TAPS - 1; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  always_comb begin
    win0[0] = sample_in;
    for (int i = 1; i < TAPS; i++) begin
      win0[i] = hist[i-1];
    end
  end

  // The accumulator enters the chain holding the rounding half; each cell
  // adds its tap product and clamps, in tap order as required.
  assign valid_c[0] = in_valid;
  assign acc_c[0]   = ROUND_HALF;
  assign win_c[0]   = win0;

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    sqff_cell #(
      .TAPS(TAPS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .valid_in  (valid_c[k]),
      .acc_in    (acc_c[k]),
      .win_in    (win_c[k]),
      .coef      (coefs[k]),
      .valid_out (valid_c[k+1]),
      .acc_out   (acc_c[k+1]),
      .win_out   (win_c[k+1])
    );
  end

  // The last cell's registers are the output register. The clamped sum lies
  // in -2^30 .. 2^30-1, so the arithmetic shift by 15 is a plain slice.
  assign out_valid  = valid_c[TAPS];
  assign sample_out = acc_c[TAPS][ACC_W-1 -: SAMPLE_W];

endmodule

@@ design/sqff_checker.sv @@
// Port-level checker for the saturating Q15 FIR filter and its binding.
// Depends on sqff_pkg and the top level saturating_q15_fir_filter.
module sqff_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input sqff_pkg::sample_t sample_out
);

  // Nothing is offered in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // The input only stalls when a finished result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A result that is not taken is never lost.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sample_out)))
    else $error("stalled result changed or dropped");

endmodule

bind saturating_q15_fir_filter sqff_checker u_sqff_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out)
);
